// File: hw/rtl/sao_pkg.sv
`default_nettype none

package sao_pkg;

  // Channel width; every internal width below follows from it.
  localparam int CHANNEL_BITS = 8;

  localparam int CB = CHANNEL_BITS;
  // Weights fa*M and ba*(M-fa), and their sum D, fit in two channels.
  localparam int WW = 2 * CB;
  // Products of a channel and a weight.
  localparam int PW = 3 * CB;
  // Divider numerator 2n+D and pre-shifted divisor.
  localparam int NW = 3 * CB + 1;
  // Quotient bits, one divider stage each.
  localparam int QB = CB;

  // Full scale, standing for 1.0.
  localparam logic [CB-1:0] CHAN_MAX = {CB{1'b1}};

  // Divider lanes, one per colour channel.
  localparam int NLANE = 3;
  localparam int LANE_RED = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE = 2;

  // Input word: front pixel over back pixel.
  typedef struct packed {
    logic [CB-1:0] front_red;
    logic [CB-1:0] front_green;
    logic [CB-1:0] front_blue;
    logic [CB-1:0] front_alpha;
    logic [CB-1:0] back_red;
    logic [CB-1:0] back_green;
    logic [CB-1:0] back_blue;
    logic [CB-1:0] back_alpha;
  } sao_in_t;

  // Output word: composited pixel.
  typedef struct packed {
    logic [CB-1:0] out_red;
    logic [CB-1:0] out_green;
    logic [CB-1:0] out_blue;
    logic [CB-1:0] out_alpha;
    logic          fully_clear;
  } sao_out_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] den;
    logic [QB-1:0] quo;
  } sao_lane_t;

  // Everything that travels down the divider pipeline.
  typedef struct packed {
    sao_lane_t [NLANE-1:0] lane;
    logic [CB-1:0]         alpha;
    logic                  clear;
  } sao_div_t;

endpackage

`default_nettype wire

// File: hw/rtl/sao_div_stage.sv
`default_nettype none

module sao_div_stage (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    valid_i,
  output logic                   ready_o,
  input  wire sao_pkg::sao_div_t data_i,
  output logic                   valid_o,
  input  wire                    ready_i,
  output sao_pkg::sao_div_t      data_o
);
  import sao_pkg::*;

  logic     valid_q;
  sao_div_t data_q;
  sao_div_t data_d;

  // The stage takes a new word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;

  // One quotient bit per lane: trial subtract, then halve the divisor.
  always_comb begin
    data_d = data_i;
    for (int k = 0; k < NLANE; k++) begin
      if (data_i.lane[k].rem >= data_i.lane[k].den) begin
        data_d.lane[k].rem = data_i.lane[k].rem - data_i.lane[k].den;
        data_d.lane[k].quo = {data_i.lane[k].quo[QB-2:0], 1'b1};
      end else begin
        data_d.lane[k].quo = {data_i.lane[k].quo[QB-2:0], 1'b0};
      end
      data_d.lane[k].den = data_i.lane[k].den >> 1;
    end
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/straight_alpha_over_blend.sv
// Straight-alpha "over" compositor. Each word carries a front and a back RGBA
// pixel, neither premultiplied, and returns the front composited over the
// back: alpha is round(D/M) and each colour round((fc*fa*M + bc*ba*(M-fa))/D)
// with D = fa*M + ba*(M-fa), M full scale, rounding half up. When both alphas
// are zero the word is all zeros with fully_clear set. The block takes one
// word per clock when the output is not stalled: one stage forms the
// weights, one the products, one the sums and divider operands, then eight
// stages of a pipelined restoring divider each settle one quotient bit for
// the three colour channels in parallel. Alpha is a division by the
// constant M, done with a shift and an add in the operand stage, and rides
// along with the colours.
// Each stage holds its word while the next is full, so back-pressure fills
// bubbles first and loses nothing; the last stage is the output register.
`default_nettype none

module straight_alpha_over_blend (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire sao_pkg::sao_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output sao_pkg::sao_out_t     out_data_o
);
  import sao_pkg::*;

  // Stage 1: weights.
  logic          s1_valid_q;
  logic          s1_ready;
  logic [CB-1:0] s1_fc_q [3];
  logic [CB-1:0] s1_bc_q [3];
  logic [WW-1:0] s1_wf_q, s1_wf_d;
  logic [WW-1:0] s1_wb_q, s1_wb_d;

  // Stage 2: products and weight sum.
  logic          s2_valid_q;
  logic          s2_ready;
  logic [PW-1:0] s2_pf_q [3];
  logic [PW-1:0] s2_pb_q [3];
  logic [WW-1:0] s2_d_q, s2_d_d;

  // Stage 3: divider operands, then the divider stages.
  logic     div_valid [QB+1];
  logic     div_ready [QB+1];
  sao_div_t div_data  [QB+1];
  sao_div_t s3_d;
  logic [PW-1:0] s3_n;
  logic [NW-1:0] s3_den;
  logic [WW:0]   s3_alpha_x;
  logic [WW:0]   s3_alpha_sum;

  assign in_ready_o = !s1_valid_q || s1_ready;
  assign s1_ready   = !s2_valid_q || s2_ready;
  assign s2_ready   = !div_valid[0] || div_ready[0];

  // Weights of the front and the back pixel.
  assign s1_wf_d = WW'(in_data_i.front_alpha) * WW'(CHAN_MAX);
  assign s1_wb_d = WW'(in_data_i.back_alpha) * WW'(CHAN_MAX - in_data_i.front_alpha);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_fc_q[0] <= in_data_i.front_red;
      s1_fc_q[1] <= in_data_i.front_green;
      s1_fc_q[2] <= in_data_i.front_blue;
      s1_bc_q[0] <= in_data_i.back_red;
      s1_bc_q[1] <= in_data_i.back_green;
      s1_bc_q[2] <= in_data_i.back_blue;
      s1_wf_q    <= s1_wf_d;
      s1_wb_q    <= s1_wb_d;
    end
  end

  // Colour products and the weight sum, which never exceeds M*M.
  assign s2_d_d = s1_wf_q + s1_wb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s1_valid_q) begin
      for (int k = 0; k < 3; k++) begin
        s2_pf_q[k] <= PW'(s1_fc_q[k]) * PW'(s1_wf_q);
        s2_pb_q[k] <= PW'(s1_bc_q[k]) * PW'(s1_wb_q);
      end
      s2_d_q <= s2_d_d;
    end
  end

  // Divider operands: round(a/b) is floor((2a+b)/(2b)). The divisor starts
  // shifted up by QB-1 bits. A zero weight sum gives a zero numerator, so a
  // divisor of one yields zero colours without a later override.
  always_comb begin
    s3_d       = '0;
    s3_d.clear = (s2_d_q == '0);
    if (s3_d.clear) begin
      s3_den = NW'(1) << (QB - 1);
    end else begin
      s3_den = NW'({s2_d_q, 1'b0}) << (QB - 1);
    end
    for (int k = 0; k < NLANE; k++) begin
      s3_n = s2_pf_q[k] + s2_pb_q[k];
      s3_d.lane[k].rem = NW'({s3_n, 1'b0}) + NW'(s2_d_q);
      s3_d.lane[k].den = s3_den;
    end
    s3_n = '0;
    // Alpha is floor((D + M/2) / M), as M is odd. For x below M*(M+1),
    // floor(x/M) equals (x + 1 + (x >> CB)) >> CB.
    s3_alpha_x   = {1'b0, s2_d_q} + (WW+1)'(CHAN_MAX >> 1);
    s3_alpha_sum = s3_alpha_x + (WW+1)'(1) + (s3_alpha_x >> CB);
    s3_d.alpha   = CB'(s3_alpha_sum >> CB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid[0] <= 1'b0;
    end else if (s2_ready) begin
      div_valid[0] <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s2_valid_q) begin
      div_data[0] <= s3_d;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar g = 0; g < QB; g++) begin : g_div
    sao_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .ready_o (div_ready[g]),
      .data_i  (div_data[g]),
      .valid_o (div_valid[g+1]),
      .ready_i (div_ready[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  assign div_ready[QB] = out_ready_i;

  // The last divider stage is the output register.
  assign out_valid_o            = div_valid[QB];
  assign out_data_o.out_red     = div_data[QB].lane[LANE_RED].quo;
  assign out_data_o.out_green   = div_data[QB].lane[LANE_GREEN].quo;
  assign out_data_o.out_blue    = div_data[QB].lane[LANE_BLUE].quo;
  assign out_data_o.out_alpha   = div_data[QB].alpha;
  assign out_data_o.fully_clear = div_data[QB].clear;

endmodule

`default_nettype wire

// File: hw/rtl/sao_checker.sv
`default_nettype none

module sao_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_ready_o,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire sao_pkg::sao_out_t out_data_o
);
  import sao_pkg::*;

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // A fully clear result carries no colour.
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fully_clear |->
      out_data_o.out_red == '0 && out_data_o.out_green == '0 &&
      out_data_o.out_blue == '0)
    else $error("fully clear word with nonzero colour");

  // Alpha is zero exactly when the result is fully clear.
  a_clear_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fully_clear == (out_data_o.out_alpha == '0))
    else $error("alpha and fully_clear disagree");

  // With the output side ready, every stage moves, so the input is ready.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while the output was ready");

  // Nothing leaves the pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight after reset");

endmodule

bind straight_alpha_over_blend sao_checker u_sao_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: tb/sv/straight_alpha_over_blend_test.sv
`timescale 1ns / 100ps

module straight_alpha_over_blend_test;
  import sao_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_LEN = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 40;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  sao_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  sao_out_t out_data_o;

  // Composited pixels still owed by the block, oldest first.
  sao_out_t expected_pixels[$];
  int       fail_count = 0;
  int       result_count = 0;
  int       send_idle_pct = 33;
  int       ready_idle_pct = 33;
  logic     hold_request = 1'b0;
  int       hold_left = 0;

  straight_alpha_over_blend u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Division rounding half up, as the block does it.
  function automatic logic [CB-1:0] round_div(input longint unsigned num,
                                              input longint unsigned den);
    return CB'((2 * num + den) / (2 * den));
  endfunction

  // Porter-Duff over on straight-alpha pixels.
  function automatic sao_out_t blend_pixel(input sao_in_t px);
    longint unsigned full, w_front, w_back, w_sum;
    sao_out_t res;
    full = 64'(CHAN_MAX);
    w_front = px.front_alpha * full;
    w_back = px.back_alpha * (full - px.front_alpha);
    w_sum = w_front + w_back;
    res = '0;
    if (w_sum == 0) begin
      // Both pixels fully transparent.
      res.fully_clear = 1'b1;
    end else begin
      res.out_red   = round_div(px.front_red * w_front + px.back_red * w_back, w_sum);
      res.out_green = round_div(px.front_green * w_front + px.back_green * w_back, w_sum);
      res.out_blue  = round_div(px.front_blue * w_front + px.back_blue * w_back, w_sum);
      res.out_alpha = round_div(w_sum, full);
    end
    return res;
  endfunction

  function automatic sao_in_t make_pixel(input int fr, input int fg, input int fb,
                                         input int fa, input int br, input int bg,
                                         input int bb, input int ba);
    sao_in_t px;
    px.front_red = CB'(fr);
    px.front_green = CB'(fg);
    px.front_blue = CB'(fb);
    px.front_alpha = CB'(fa);
    px.back_red = CB'(br);
    px.back_green = CB'(bg);
    px.back_blue = CB'(bb);
    px.back_alpha = CB'(ba);
    return px;
  endfunction

  // Alphas lean towards the edges so that the special cases turn up often.
  function automatic logic [CB-1:0] pick_alpha();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return CHAN_MAX;
      2: return CB'(1);
      3: return CHAN_MAX - CB'(1);
      default: return CB'($urandom_range(CHAN_MAX, 0));
    endcase
  endfunction

  function automatic sao_in_t random_pixel();
    sao_in_t px;
    px.front_red = CB'($urandom_range(CHAN_MAX, 0));
    px.front_green = CB'($urandom_range(CHAN_MAX, 0));
    px.front_blue = CB'($urandom_range(CHAN_MAX, 0));
    px.front_alpha = pick_alpha();
    px.back_red = CB'($urandom_range(CHAN_MAX, 0));
    px.back_green = CB'($urandom_range(CHAN_MAX, 0));
    px.back_blue = CB'($urandom_range(CHAN_MAX, 0));
    px.back_alpha = pick_alpha();
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [CB-1:0] got,
                             input logic [CB-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  // Offers one word after a random gap and leaves valid high once it is taken.
  task automatic send_pixel(input sao_in_t px);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_pixels.push_back(blend_pixel(px));
  endtask

  task automatic wait_drained();
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Sink side: random stalls, and a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      hold_left = HOLD_LEN - 1;
      hold_request <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= ready_idle_pct);
    end
  end

  // Each accepted result word is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    sao_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  result_count));
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", out_data_o.out_red, want.out_red);
        check_field("out_green", out_data_o.out_green, want.out_green);
        check_field("out_blue", out_data_o.out_blue, want.out_blue);
        check_field("out_alpha", out_data_o.out_alpha, want.out_alpha);
        check_field("fully_clear", CB'(out_data_o.fully_clear), CB'(want.fully_clear));
      end
      result_count++;
    end
  end

  // The run is abandoned when no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("straight_alpha_over_blend_test: FAIL");
    $finish;
  end

  // Edge alphas, transparent pairs, opaque fronts and rounding corners.
  task automatic test_directed();
    sao_in_t cases[$];
    cases.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
    cases.push_back(make_pixel(255, 255, 255, 0, 255, 255, 255, 0));
    cases.push_back(make_pixel(200, 100, 50, 255, 10, 20, 30, 255));
    cases.push_back(make_pixel(1, 2, 3, 255, 255, 255, 255, 0));
    cases.push_back(make_pixel(255, 255, 255, 255, 255, 255, 255, 255));
    cases.push_back(make_pixel(255, 255, 255, 0, 12, 34, 56, 255));
    cases.push_back(make_pixel(90, 180, 45, 0, 7, 250, 128, 1));
    cases.push_back(make_pixel(77, 154, 231, 1, 255, 0, 255, 0));
    cases.push_back(make_pixel(255, 0, 255, 1, 0, 255, 0, 255));
    cases.push_back(make_pixel(0, 128, 255, 254, 255, 127, 0, 1));
    cases.push_back(make_pixel(255, 0, 128, 128, 0, 255, 127, 128));
    cases.push_back(make_pixel(170, 85, 240, 127, 15, 51, 204, 200));
    cases.push_back(make_pixel(0, 0, 0, 255, 255, 255, 255, 0));
    cases.push_back(make_pixel(255, 255, 255, 64, 0, 0, 0, 255));
    cases.push_back(make_pixel(255, 0, 255, 1, 0, 255, 0, 1));
    cases.push_back(make_pixel(1, 254, 127, 2, 254, 1, 128, 253));
    foreach (cases[i]) send_pixel(cases[i]);
  endtask

  // Random pixels with random gaps on both sides.
  task automatic test_random_idle(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // A long stretch at full rate with no gaps anywhere.
  task automatic test_back_to_back(input int count);
    send_idle_pct = 0;
    ready_idle_pct = 0;
    repeat (count) send_pixel(random_pixel());
    send_idle_pct = 33;
    ready_idle_pct = 33;
  endtask

  // The sink holds off while words keep coming, so the pipeline fills.
  task automatic test_backpressure(input int count);
    send_idle_pct = 0;
    hold_request <= 1'b1;
    repeat (count) send_pixel(random_pixel());
    send_idle_pct = 33;
  endtask

  // Bursts of random length, each followed by a full drain of the block.
  task automatic test_drain_pauses(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(40, 1);
      repeat (burst) send_pixel(random_pixel());
      sent += burst;
      in_valid_i <= 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_idle(400);
    test_back_to_back(300);
    test_backpressure(60);
    test_drain_pauses(250);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    if (fail_count == 0) begin
      $display("straight_alpha_over_blend_test: PASS");
    end else begin
      $display("straight_alpha_over_blend_test: FAIL");
    end
    $finish;
  end

endmodule

// File: straight_alpha_over_blend.f
hw/rtl/sao_pkg.sv
hw/rtl/sao_div_stage.sv
hw/rtl/straight_alpha_over_blend.sv
hw/rtl/sao_checker.sv
tb/sv/straight_alpha_over_blend_test.sv
